/* rtl/atilt_pkg.sv */
// Shared types, constants and arctangent table functions for the tilt angle block.
package atilt_pkg;

    localparam int RAW_W    = 16;
    localparam int FS_W     = 14;
    localparam int SC_W     = 15;
    localparam int ABS_W    = 15;
    localparam int DEG_W    = 9;
    localparam int PROD_W   = RAW_W + FS_W + 1;
    localparam int SCALE_SH = 15;
    localparam int NITER    = 48;
    localparam int VEC_FRAC = 46;
    localparam int ANG_FRAC = 40;
    localparam int XY_W     = 64;
    localparam int Z_W      = 49;
    localparam int MAG_W    = 48;

    localparam logic [FS_W-1:0] FS_RESET = FS_W'(2000);

    // angles in 2^-40 degree
    localparam logic signed [Z_W-1:0] Z_LIM   = Z_W'(64'd45 << ANG_FRAC);
    localparam logic [MAG_W-1:0]      DEG90   = MAG_W'(64'd90 << ANG_FRAC);
    localparam logic [MAG_W-1:0]      HALF    = MAG_W'(64'd1 << (ANG_FRAC - 1));
    localparam logic [MAG_W-1:0]      DEG180H = MAG_W'((64'd180 << ANG_FRAC)
                                                       + (64'd1 << (ANG_FRAC - 1)));

    typedef struct packed {
        logic swap;
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_flags;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [SC_W-1:0] sx;
        logic signed [SC_W-1:0] sy;
        t_flags                 flags;
    } t_cell;

    // shift-subtract quotient, used only while elaborating constants
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], a[k]};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees, Q40, by integer power series times 180/pi
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0]  pi17;
        logic [63:0]  num;
        logic [63:0]  c;
        logic [63:0]  rem;
        logic [63:0]  p;
        logic [63:0]  sum;
        logic [63:0]  n;
        logic [63:0]  term;
        logic [127:0] prod;
        pi17 = 64'd314159265358979323;
        num  = 64'd18000000000000000000;
        c    = udiv64(num, pi17);
        rem  = num - c * pi17;
        for (int k = 0; k < 56; k++) begin
            rem = rem << 1;
            c   = c << 1;
            if (rem >= pi17) begin
                rem  = rem - pi17;
                c[0] = 1'b1;
            end
        end
        if (i == 0) begin
            return 64'd45 << ANG_FRAC;
        end
        p   = 64'd1 << (62 - i);
        sum = '0;
        n   = '0;
        while (p != 0) begin
            term = udiv64(p, (n << 1) + 64'd1);
            if (!n[0]) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            n = n + 64'd1;
            if (2 * i >= 62) begin
                p = '0;
            end else begin
                p = p >> (2 * i);
            end
        end
        prod = {64'd0, sum} * {64'd0, c};
        return prod[127:64] >> 14;
    endfunction

endpackage

/* rtl/accel_tilt_angle.sv */
// Top level: accelerometer tilt angle, scaling front end, CORDIC cell row, rounding back end.
//
//   channel   direction  handshake              payload
//   sample    in         i_valid / o_stall      i_raw_x, i_raw_y
//   result    out        o_valid / i_stall      o_scaled_x, o_scaled_y, o_tilt_deg
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (full scale, milli-g)
//
// One sample pair per cycle while neither o_stall nor i_stall holds the flow; the path runs
// through input, scale, fold, 48 CORDIC cells, unfold and output, plus the input skid register when in use.
// All stages share one advance enable, set from the output register's valid and i_stall.
// Reset is synchronous, active low; it empties the pipe and loads full scale 2000.
// o_stall comes straight from the input skid register.
module accel_tilt_angle (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atilt_pkg::FS_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [atilt_pkg::RAW_W-1:0]  i_raw_x,
    input  logic signed [atilt_pkg::RAW_W-1:0]  i_raw_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [atilt_pkg::SC_W-1:0]   o_scaled_x,
    output logic signed [atilt_pkg::SC_W-1:0]   o_scaled_y,
    output logic signed [atilt_pkg::DEG_W-1:0]  o_tilt_deg
);

    logic [atilt_pkg::FS_W-1:0] r_full_scale;
    logic                       w_en;
    logic                       w_valid [0:atilt_pkg::NITER];
    atilt_pkg::t_cell           w_data  [0:atilt_pkg::NITER];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= atilt_pkg::FS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_full_scale <= i_cfg_data;
        end
    end

    atilt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .i_full_scale (r_full_scale),
        .i_en         (w_en),
        .o_valid      (w_valid[0]),
        .o_data       (w_data[0])
    );

    for (genvar g = 0; g < atilt_pkg::NITER; g++) begin : g_cell
        atilt_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    atilt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[atilt_pkg::NITER]),
        .i_data     (w_data[atilt_pkg::NITER]),
        .o_en       (w_en),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_scaled_x (o_scaled_x),
        .o_scaled_y (o_scaled_y),
        .o_tilt_deg (o_tilt_deg)
    );

endmodule

/* rtl/atilt_front.sv */
// Input skid register, milli-g scaling and octant folding ahead of the CORDIC row.
module atilt_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [atilt_pkg::RAW_W-1:0]   i_raw_x,
    input  logic signed [atilt_pkg::RAW_W-1:0]   i_raw_y,
    input  logic        [atilt_pkg::FS_W-1:0]    i_full_scale,
    input  logic                                 i_en,
    output logic                                 o_valid,
    output atilt_pkg::t_cell                     o_data
);

    logic                                r_skid_valid;
    logic signed [atilt_pkg::RAW_W-1:0]  r_skid_x;
    logic signed [atilt_pkg::RAW_W-1:0]  r_skid_y;
    logic                                r_s0_valid;
    logic signed [atilt_pkg::RAW_W-1:0]  r_s0_x;
    logic signed [atilt_pkg::RAW_W-1:0]  r_s0_y;
    logic                                r_s1_valid;
    logic signed [atilt_pkg::SC_W-1:0]   r_s1_sx;
    logic signed [atilt_pkg::SC_W-1:0]   r_s1_sy;
    logic                                r_s2_valid;
    atilt_pkg::t_cell                    r_s2;
    atilt_pkg::t_cell                    n_s2;

    logic                                w_accept;
    logic signed [atilt_pkg::PROD_W-1:0] w_px;
    logic signed [atilt_pkg::PROD_W-1:0] w_py;
    logic signed [atilt_pkg::PROD_W-1:0] w_fs;
    logic [atilt_pkg::ABS_W-1:0]         w_ax;
    logic [atilt_pkg::ABS_W-1:0]         w_ay;
    logic [atilt_pkg::ABS_W-1:0]         w_u;
    logic [atilt_pkg::ABS_W-1:0]         w_v;

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (i_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_en && w_accept) begin
            r_skid_x <= i_raw_x;
            r_skid_y <= i_raw_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s0_valid <= r_skid_valid || w_accept;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // floor(raw * fs / 2^15) is the product's bits above the shift
    assign w_fs = atilt_pkg::PROD_W'($signed({1'b0, i_full_scale}));
    assign w_px = atilt_pkg::PROD_W'(r_s0_x) * w_fs;
    assign w_py = atilt_pkg::PROD_W'(r_s0_y) * w_fs;

    always_comb begin
        w_ax = r_s1_sx[atilt_pkg::SC_W-1] ? atilt_pkg::ABS_W'(-r_s1_sx)
                                          : atilt_pkg::ABS_W'(r_s1_sx);
        w_ay = r_s1_sy[atilt_pkg::SC_W-1] ? atilt_pkg::ABS_W'(-r_s1_sy)
                                          : atilt_pkg::ABS_W'(r_s1_sy);
        n_s2.flags.swap  = w_ax > w_ay;
        n_s2.flags.neg_x = r_s1_sx[atilt_pkg::SC_W-1];
        n_s2.flags.neg_y = r_s1_sy[atilt_pkg::SC_W-1];
        n_s2.flags.zero  = (w_ax == '0) && (w_ay == '0);
        w_u    = n_s2.flags.swap ? w_ax : w_ay;
        w_v    = n_s2.flags.swap ? w_ay : w_ax;
        n_s2.x = $signed(atilt_pkg::XY_W'(w_u) << atilt_pkg::VEC_FRAC);
        n_s2.y = $signed(atilt_pkg::XY_W'(w_v) << atilt_pkg::VEC_FRAC);
        n_s2.z = '0;
        n_s2.sx = r_s1_sx;
        n_s2.sy = r_s1_sy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_x  <= r_skid_valid ? r_skid_x : i_raw_x;
            r_s0_y  <= r_skid_valid ? r_skid_y : i_raw_y;
            r_s1_sx <= w_px[atilt_pkg::SCALE_SH+atilt_pkg::SC_W-1:atilt_pkg::SCALE_SH];
            r_s1_sy <= w_py[atilt_pkg::SCALE_SH+atilt_pkg::SC_W-1:atilt_pkg::SCALE_SH];
            r_s2    <= n_s2;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2;

endmodule

/* rtl/atilt_cell.sv */
// One vectoring CORDIC iteration with its pipeline register.
module atilt_cell #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  atilt_pkg::t_cell i_data,
    output logic             o_valid,
    output atilt_pkg::t_cell o_data
);

    localparam logic signed [atilt_pkg::Z_W-1:0] ATAN =
        atilt_pkg::Z_W'(atilt_pkg::atan_entry(STAGE));

    logic                                r_valid;
    atilt_pkg::t_cell                    r_data;
    atilt_pkg::t_cell                    n_data;
    logic signed [atilt_pkg::XY_W-1:0]   w_xs;
    logic signed [atilt_pkg::XY_W-1:0]   w_ys;
    logic                                w_down;

    always_comb begin
        w_xs   = $signed(i_data.x) >>> STAGE;
        w_ys   = $signed(i_data.y) >>> STAGE;
        // rotate toward the x axis while y is still positive
        w_down = !i_data.y[atilt_pkg::XY_W-1] && (i_data.y != '0);
        n_data = i_data;
        if (w_down) begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + ATAN;
        end else begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/atilt_back.sv */
// Angle clamp, quadrant unfolding, rounding to degrees and the output register.
module atilt_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  atilt_pkg::t_cell                    i_data,
    output logic                                o_en,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [atilt_pkg::SC_W-1:0]   o_scaled_x,
    output logic signed [atilt_pkg::SC_W-1:0]   o_scaled_y,
    output logic signed [atilt_pkg::DEG_W-1:0]  o_tilt_deg
);

    logic                                r_a_valid;
    logic [atilt_pkg::MAG_W-1:0]         r_a_mag;
    atilt_pkg::t_flags                   r_a_flags;
    logic signed [atilt_pkg::SC_W-1:0]   r_a_sx;
    logic signed [atilt_pkg::SC_W-1:0]   r_a_sy;
    logic                                r_out_valid;
    logic signed [atilt_pkg::SC_W-1:0]   r_out_sx;
    logic signed [atilt_pkg::SC_W-1:0]   r_out_sy;
    logic signed [atilt_pkg::DEG_W-1:0]  r_out_deg;

    logic [atilt_pkg::MAG_W-1:0]         n_a_mag;
    logic signed [atilt_pkg::DEG_W-1:0]  n_out_deg;
    logic signed [atilt_pkg::Z_W-1:0]    w_zc;
    logic [atilt_pkg::MAG_W-1:0]         w_zu;
    logic [atilt_pkg::MAG_W-1:0]         w_rnd;
    logic [atilt_pkg::DEG_W-1:0]         w_dmag;

    assign o_en = !r_out_valid || !i_stall;

    always_comb begin
        if (i_data.z[atilt_pkg::Z_W-1]) begin
            w_zc = '0;
        end else if ($signed(i_data.z) > atilt_pkg::Z_LIM) begin
            w_zc = atilt_pkg::Z_LIM;
        end else begin
            w_zc = i_data.z;
        end
        w_zu    = atilt_pkg::MAG_W'(w_zc);
        n_a_mag = i_data.flags.swap ? (atilt_pkg::DEG90 - w_zu) : w_zu;
    end

    // 180 - mag plus one half folds into a single subtract
    always_comb begin
        w_rnd  = r_a_flags.neg_y ? (atilt_pkg::DEG180H - r_a_mag) : (r_a_mag + atilt_pkg::HALF);
        w_dmag = {1'b0, w_rnd[atilt_pkg::MAG_W-1:atilt_pkg::ANG_FRAC]};
        if (r_a_flags.zero) begin
            n_out_deg = '0;
        end else if (r_a_flags.neg_x) begin
            n_out_deg = $signed(-w_dmag);
        end else begin
            n_out_deg = $signed(w_dmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_a_valid   <= i_valid;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_a_mag   <= n_a_mag;
            r_a_flags <= i_data.flags;
            r_a_sx    <= i_data.sx;
            r_a_sy    <= i_data.sy;
            r_out_sx  <= r_a_sx;
            r_out_sy  <= r_a_sy;
            r_out_deg <= n_out_deg;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_scaled_x = r_out_sx;
    assign o_scaled_y = r_out_sy;
    assign o_tilt_deg = r_out_deg;

endmodule

/* rtl/atilt_chk.sv */
// Port-level checker for the tilt angle block, bound to the top level.
module atilt_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [atilt_pkg::SC_W-1:0]   o_scaled_x,
    input logic signed [atilt_pkg::SC_W-1:0]   o_scaled_y,
    input logic signed [atilt_pkg::DEG_W-1:0]  o_tilt_deg
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tilt_deg) && $stable(o_scaled_x)
                               && $stable(o_scaled_y))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result shown right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt_deg >= -9'sd180) && (o_tilt_deg <= 9'sd180))
        else $error("tilt angle out of range");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_scaled_x > 0) ? (o_tilt_deg >= 0) : (o_tilt_deg <= 0))
                    || (o_scaled_x == 0 && o_scaled_y < 0 && o_tilt_deg == 9'sd180))
        else $error("tilt angle sign disagrees with x");

    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_scaled_x == 0) && (o_scaled_y >= 0) |-> o_tilt_deg == 0)
        else $error("angle on the positive y axis is not zero");

endmodule

bind accel_tilt_angle atilt_chk u_atilt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_scaled_x (o_scaled_x),
    .o_scaled_y (o_scaled_y),
    .o_tilt_deg (o_tilt_deg)
);
